>>> hdl/vtdi_pkg.sv
// ----------------------------------------------------------------------------
// vtdi_pkg
// shared constants and types of the vertex triple dedup indexer
// ----------------------------------------------------------------------------
package vtdi_pkg;

  localparam int MAX_VERTICES = 1024;
  localparam int INDEX_WIDTH  = 16;
  localparam int NUM_CELLS    = 8;

  localparam int SLOT_W  = $clog2(MAX_VERTICES);
  localparam int COUNT_W = SLOT_W + 1;
  localparam int CELL_W  = $clog2(NUM_CELLS);
  localparam int ROW_W   = SLOT_W - CELL_W;
  localparam int ROWS    = MAX_VERTICES / NUM_CELLS;
  localparam int ENTRY_W = 3 * INDEX_WIDTH;

  // match result handed from one cell to the next
  typedef struct packed {
    logic              hit;
    logic [SLOT_W-1:0] slot;
  } link_t;

  // append request seen by every cell
  typedef struct packed {
    logic               en;
    logic [SLOT_W-1:0]  slot;
    logic [ENTRY_W-1:0] data;
  } wr_t;

  typedef enum logic [2:0] {
    ST_IDLE    = 3'b001,
    ST_SCAN    = 3'b010,
    ST_RESOLVE = 3'b100
  } state_t;

endpackage

>>> hdl/vtdi_ram.sv
// ----------------------------------------------------------------------------
// vtdi_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module vtdi_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

>>> hdl/vtdi_cell.sv
// ----------------------------------------------------------------------------
// vtdi_cell
// one bank of the triple table: stores every entry whose slot has this cell's
// low bits, compares one row per cycle and passes the match to its neighbor
// ----------------------------------------------------------------------------
module vtdi_cell (
  input  logic                        clk,
  input  logic [vtdi_pkg::CELL_W-1:0] cell_id,
  input  logic [vtdi_pkg::ROW_W-1:0]  rd_row,
  input  logic [vtdi_pkg::ROW_W-1:0]  cmp_row,
  input  logic [vtdi_pkg::COUNT_W-1:0] count,
  input  logic [vtdi_pkg::ENTRY_W-1:0] query,
  input  vtdi_pkg::wr_t               wr,
  input  vtdi_pkg::link_t             link_in,
  output vtdi_pkg::link_t             link_out
);

  logic                          wr_en;
  logic [vtdi_pkg::ENTRY_W-1:0]  rd_data;
  logic [vtdi_pkg::SLOT_W-1:0]   my_slot;
  logic                          entry_valid;
  logic                          match;

  assign wr_en = wr.en && (wr.slot[vtdi_pkg::CELL_W-1:0] == cell_id);

  vtdi_ram #(
    .WIDTH (vtdi_pkg::ENTRY_W),
    .DEPTH (vtdi_pkg::ROWS)
  ) u_bank (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr.slot[vtdi_pkg::SLOT_W-1:vtdi_pkg::CELL_W]),
    .wr_data (wr.data),
    .rd_addr (rd_row),
    .rd_data (rd_data)
  );

  assign my_slot     = {cmp_row, cell_id};
  // only entries below the fill count take part
  assign entry_valid = {1'b0, my_slot} < count;
  assign match       = entry_valid && (rd_data == query);

  always_comb begin
    if (link_in.hit) begin
      link_out = link_in;
    end else begin
      link_out.hit  = match;
      link_out.slot = match ? my_slot : '0;
    end
  end

endmodule

>>> hdl/vertex_triple_dedup_indexer.sv
// ----------------------------------------------------------------------------
// vertex_triple_dedup_indexer
// dedup of position/texcoord/normal triples into vertex slots
// ----------------------------------------------------------------------------
// latency, accept to result, depends on the path: an item goes straight to ST_RESOLVE when
// the table is empty or the model restarts, else it passes through ST_SCAN, which ends early on a hit
// throughput: one item at a time; busy drops as the result goes out, so the next
// item is taken on the edge that accepts the result; the row sweep sets the rate
// out_valid pulses for one cycle and the receiver cannot stall it
// reset (rst_n low, synchronous) empties the table; no clearing pass needed
module vertex_triple_dedup_indexer (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start,
  output logic                             busy,
  input  logic                             in_start_model,
  input  logic [vtdi_pkg::INDEX_WIDTH-1:0] in_position_index,
  input  logic [vtdi_pkg::INDEX_WIDTH-1:0] in_texcoord_index,
  input  logic [vtdi_pkg::INDEX_WIDTH-1:0] in_normal_index,
  output logic                             out_valid,
  output logic [vtdi_pkg::SLOT_W-1:0]      out_vertex_slot,
  output logic                             out_is_new,
  output logic                             out_overflow,
  output logic [vtdi_pkg::COUNT_W-1:0]     out_unique_count
);

  vtdi_pkg::state_t state_r, state_nxt;

  logic [vtdi_pkg::ENTRY_W-1:0] query_r, query_nxt;
  logic [vtdi_pkg::COUNT_W-1:0] count_r, count_nxt;
  logic [vtdi_pkg::ROW_W-1:0]   issue_row_r, issue_row_nxt;
  logic                         issue_v_r, issue_v_nxt;
  logic [vtdi_pkg::ROW_W-1:0]   cmp_row_r, cmp_row_nxt;
  logic                         cmp_v_r, cmp_v_nxt;
  logic                         hit_r, hit_nxt;
  logic [vtdi_pkg::SLOT_W-1:0]  hit_slot_r, hit_slot_nxt;

  logic                         out_valid_r, out_valid_nxt;
  logic [vtdi_pkg::SLOT_W-1:0]  out_slot_r, out_slot_nxt;
  logic                         out_new_r, out_new_nxt;
  logic                         out_ovf_r, out_ovf_nxt;
  logic [vtdi_pkg::COUNT_W-1:0] out_count_r, out_count_nxt;

  logic                         accept;
  logic [vtdi_pkg::COUNT_W-1:0] count_eff;
  logic [vtdi_pkg::COUNT_W-1:0] count_m1;
  logic [vtdi_pkg::ROW_W-1:0]   last_row;
  logic                         full;
  vtdi_pkg::wr_t                wr;
  vtdi_pkg::link_t              links [vtdi_pkg::NUM_CELLS+1];

  assign busy     = (state_r != vtdi_pkg::ST_IDLE);
  assign accept   = start && !busy;
  assign count_eff = in_start_model ? '0 : count_r;
  assign count_m1 = count_r - vtdi_pkg::COUNT_W'(1);
  assign last_row = count_m1[vtdi_pkg::SLOT_W-1:vtdi_pkg::CELL_W];
  assign full     = (count_r == vtdi_pkg::COUNT_W'(vtdi_pkg::MAX_VERTICES));

  assign wr.en   = (state_r == vtdi_pkg::ST_RESOLVE) && !hit_r && !full;
  assign wr.slot = count_r[vtdi_pkg::SLOT_W-1:0];
  assign wr.data = query_r;

  assign links[0] = '0;

  for (genvar g = 0; g < vtdi_pkg::NUM_CELLS; g++) begin : g_cell
    vtdi_cell u_cell (
      .clk      (clk),
      .cell_id  (vtdi_pkg::CELL_W'(g)),
      .rd_row   (issue_row_r),
      .cmp_row  (cmp_row_r),
      .count    (count_r),
      .query    (query_r),
      .wr       (wr),
      .link_in  (links[g]),
      .link_out (links[g+1])
    );
  end

  always_comb begin
    state_nxt     = state_r;
    query_nxt     = query_r;
    count_nxt     = count_r;
    issue_row_nxt = issue_row_r;
    issue_v_nxt   = issue_v_r;
    cmp_row_nxt   = cmp_row_r;
    cmp_v_nxt     = 1'b0;
    hit_nxt       = hit_r;
    hit_slot_nxt  = hit_slot_r;
    out_valid_nxt = 1'b0;
    out_slot_nxt  = out_slot_r;
    out_new_nxt   = out_new_r;
    out_ovf_nxt   = out_ovf_r;
    out_count_nxt = out_count_r;

    case (state_r)
      vtdi_pkg::ST_IDLE: begin
        if (accept) begin
          query_nxt     = {in_position_index, in_texcoord_index, in_normal_index};
          count_nxt     = count_eff;
          issue_row_nxt = '0;
          hit_nxt       = 1'b0;
          hit_slot_nxt  = '0;
          if (count_eff == '0) begin
            issue_v_nxt = 1'b0;
            state_nxt   = vtdi_pkg::ST_RESOLVE;
          end else begin
            issue_v_nxt = 1'b1;
            state_nxt   = vtdi_pkg::ST_SCAN;
          end
        end
      end
      vtdi_pkg::ST_SCAN: begin
        // reads run one row ahead of the compare
        if (issue_v_r) begin
          cmp_v_nxt   = 1'b1;
          cmp_row_nxt = issue_row_r;
          if (issue_row_r == last_row) begin
            issue_v_nxt = 1'b0;
          end else begin
            issue_row_nxt = issue_row_r + vtdi_pkg::ROW_W'(1);
          end
        end
        if (cmp_v_r) begin
          if (links[vtdi_pkg::NUM_CELLS].hit) begin
            hit_nxt      = 1'b1;
            hit_slot_nxt = links[vtdi_pkg::NUM_CELLS].slot;
            issue_v_nxt  = 1'b0;
            cmp_v_nxt    = 1'b0;
            state_nxt    = vtdi_pkg::ST_RESOLVE;
          end else if (cmp_row_r == last_row) begin
            cmp_v_nxt = 1'b0;
            state_nxt = vtdi_pkg::ST_RESOLVE;
          end
        end
      end
      vtdi_pkg::ST_RESOLVE: begin
        out_valid_nxt = 1'b1;
        if (hit_r) begin
          out_slot_nxt  = hit_slot_r;
          out_new_nxt   = 1'b0;
          out_ovf_nxt   = 1'b0;
          out_count_nxt = count_r;
        end else if (!full) begin
          out_slot_nxt  = count_r[vtdi_pkg::SLOT_W-1:0];
          out_new_nxt   = 1'b1;
          out_ovf_nxt   = 1'b0;
          count_nxt     = count_r + vtdi_pkg::COUNT_W'(1);
          out_count_nxt = count_r + vtdi_pkg::COUNT_W'(1);
        end else begin
          out_slot_nxt  = '0;
          out_new_nxt   = 1'b0;
          out_ovf_nxt   = 1'b1;
          out_count_nxt = count_r;
        end
        state_nxt = vtdi_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = vtdi_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= vtdi_pkg::ST_IDLE;
      count_r     <= '0;
      issue_v_r   <= 1'b0;
      cmp_v_r     <= 1'b0;
      hit_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      issue_v_r   <= issue_v_nxt;
      cmp_v_r     <= cmp_v_nxt;
      hit_r       <= hit_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    query_r     <= query_nxt;
    issue_row_r <= issue_row_nxt;
    cmp_row_r   <= cmp_row_nxt;
    hit_slot_r  <= hit_slot_nxt;
    out_slot_r  <= out_slot_nxt;
    out_new_r   <= out_new_nxt;
    out_ovf_r   <= out_ovf_nxt;
    out_count_r <= out_count_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_vertex_slot  = out_slot_r;
  assign out_is_new       = out_new_r;
  assign out_overflow     = out_ovf_r;
  assign out_unique_count = out_count_r;

endmodule
